// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top
// depends on nothing; clock and reset named clock and reset in the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at each rising edge outside reset
`define IARU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property at each rising edge, reset included
`define IARU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/iaru_pkg.sv =====
// package of the interval arithmetic refine unit: constants, types and bound helpers
// depends on nothing
package iaru_pkg;

   localparam int unsigned DivSteps = 32;

   localparam logic signed [31:0] IntMin = 32'sh8000_0000;
   localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;

   localparam logic [2:0] ActAdd = 3'd0;
   localparam logic [2:0] ActSub = 3'd1;
   localparam logic [2:0] ActMul = 3'd2;
   localparam logic [2:0] ActDiv = 3'd3;
   localparam logic [2:0] ActRef = 3'd4;

   localparam logic [2:0] CondEq = 3'd0;
   localparam logic [2:0] CondNe = 3'd1;
   localparam logic [2:0] CondLt = 3'd2;
   localparam logic [2:0] CondLe = 3'd3;
   localparam logic [2:0] CondGt = 3'd4;
   localparam logic [2:0] CondGe = 3'd5;

   typedef struct packed {
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } iaru_ival_type;

   typedef struct packed {
      logic               is_div;
      logic               is_ref;
      logic [3:0]         neg;
      logic signed [31:0] rl;
      logic signed [31:0] ru;
      logic signed [31:0] fl;
      logic signed [31:0] fu;
   } iaru_pl_type;

   localparam iaru_ival_type Empty = '{lo: 32'sd1, hi: -32'sd1};

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v < 33'(IntMin))
         r = IntMin;
      else if (v > 33'(IntMax))
         r = IntMax;
      else
         r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v < 64'(IntMin))
         r = IntMin;
      else if (v > 64'(IntMax))
         r = IntMax;
      else
         r = v[31:0];
      return r;
   endfunction

   function automatic iaru_ival_type mk(input logic signed [31:0] lo,
                                        input logic signed [31:0] hi);
      iaru_ival_type r;
      if (lo <= hi) begin
         r.lo = lo;
         r.hi = hi;
      end else begin
         r = Empty;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic signed [31:0] dec_sat(input logic signed [31:0] v);
      return (v == IntMin) ? IntMin : v - 32'sd1;
   endfunction

   function automatic logic signed [31:0] inc_sat(input logic signed [31:0] v);
      return (v == IntMax) ? IntMax : v + 32'sd1;
   endfunction

endpackage

// ===== rtl/iaru_req_if.sv =====
// request channel of the interval arithmetic refine unit
// depends on nothing
interface iaru_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [2:0]         refine_cond;
   logic signed [31:0] a_lower;
   logic signed [31:0] a_upper;
   logic signed [31:0] b_lower;
   logic signed [31:0] b_upper;

   modport source (output valid, action, refine_cond, a_lower, a_upper, b_lower, b_upper,
                   input ready);
   modport sink   (input valid, action, refine_cond, a_lower, a_upper, b_lower, b_upper,
                   output ready);
endinterface

// ===== rtl/iaru_rsp_if.sv =====
// response channel of the interval arithmetic refine unit
// depends on nothing
interface iaru_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_lower;
   logic signed [31:0] res_upper;
   logic signed [31:0] false_lower;
   logic signed [31:0] false_upper;

   modport source (output valid, res_lower, res_upper, false_lower, false_upper,
                   input ready);
   modport sink   (input valid, res_lower, res_upper, false_lower, false_upper,
                   output ready);
endinterface

// ===== rtl/interval_arithmetic_refine_unit.sv =====
// throughput: one transaction per cycle unless the response stalls; 32-step radix-2 divider pipeline sets the depth
// a stalled response freezes the whole pipeline, nothing is lost or repeated
// reset is synchronous and active high; it clears all valid bits, payloads are not reset
// top level of the interval arithmetic refine unit
// depends on iaru_pkg, iaru_req_if, iaru_rsp_if and assert_macros.svh
`include "assert_macros.svh"

module interval_arithmetic_refine_unit
   import iaru_pkg::*;
(
   input logic        clock,
   input logic        reset,
   iaru_req_if.sink   req_if,
   iaru_rsp_if.source rsp_if
);

   localparam int unsigned Ds = DivSteps;

   logic adv;

   logic               s1_v_ff;
   logic [2:0]         s1_act_ff;
   logic [2:0]         s1_cond_ff;
   logic signed [31:0] xl_ff, xu_ff, yl_ff, yu_ff;

   iaru_pl_type        s1_pl;
   iaru_ival_type      t_iv, f_iv;
   logic signed [63:0] prod_in [4];
   logic signed [63:0] prod_ff [4];
   logic               is_mul_ff;
   logic [31:0]        mag_n [4];
   logic [31:0]        mag_d [4];
   logic [3:0]         neg_in;

   logic               v_ff   [Ds+1];
   iaru_pl_type        pl_ff  [Ds+1];
   iaru_pl_type        pl_in  [Ds];
   logic [31:0]        rem_ff [Ds+1][4];
   logic [31:0]        num_ff [Ds+1][4];
   logic [31:0]        den_ff [Ds+1][4];
   logic [31:0]        quo_ff [Ds+1][4];
   logic [31:0]        rem_in [Ds][4];
   logic [31:0]        quo_in [Ds][4];

   logic signed [63:0] pmin, pmax;
   logic signed [32:0] q [4];
   logic signed [32:0] qmin, qmax;
   iaru_pl_type        fin_pl;

   logic               out_v_ff;
   iaru_pl_type        out_pl_ff;

   assign adv          = !out_v_ff || rsp_if.ready;
   assign req_if.ready = adv;

   // stage 1 operands
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_if.valid;
      end
      if (adv) begin
         s1_act_ff  <= req_if.action;
         s1_cond_ff <= req_if.refine_cond;
         xl_ff      <= req_if.a_lower;
         xu_ff      <= req_if.a_upper;
         yl_ff      <= req_if.b_lower;
         yu_ff      <= req_if.b_upper;
      end
   end

   // add, sub, refine and divide setup
   always_comb begin
      s1_pl        = '0;
      t_iv         = '0;
      f_iv         = '0;
      s1_pl.is_ref = (s1_act_ff == ActRef);
      case (s1_cond_ff)
         CondEq: begin
            t_iv = mk(smax(xl_ff, yl_ff), smin(xu_ff, yu_ff));
            f_iv = '{lo: xl_ff, hi: xu_ff};
         end
         CondNe: begin
            t_iv = '{lo: xl_ff, hi: xu_ff};
            f_iv = mk(smax(xl_ff, yl_ff), smin(xu_ff, yu_ff));
         end
         CondLt: begin
            if (xu_ff < yl_ff) begin
               t_iv = '{lo: xl_ff, hi: xu_ff};
               f_iv = Empty;
            end else if (xl_ff >= yu_ff) begin
               t_iv = Empty;
               f_iv = '{lo: xl_ff, hi: xu_ff};
            end else begin
               t_iv = mk(xl_ff, smin(xu_ff, dec_sat(yu_ff)));
               f_iv = mk(smax(xl_ff, yl_ff), xu_ff);
            end
         end
         CondLe: begin
            if (xu_ff <= yl_ff) begin
               t_iv = '{lo: xl_ff, hi: xu_ff};
               f_iv = Empty;
            end else if (xl_ff > yu_ff) begin
               t_iv = Empty;
               f_iv = '{lo: xl_ff, hi: xu_ff};
            end else begin
               t_iv = mk(xl_ff, smin(xu_ff, yu_ff));
               f_iv = mk(smax(xl_ff, inc_sat(yl_ff)), xu_ff);
            end
         end
         CondGt: begin
            if (xl_ff > yu_ff) begin
               t_iv = '{lo: xl_ff, hi: xu_ff};
               f_iv = Empty;
            end else if (xu_ff <= yl_ff) begin
               t_iv = Empty;
               f_iv = '{lo: xl_ff, hi: xu_ff};
            end else begin
               t_iv = mk(smax(xl_ff, inc_sat(yl_ff)), xu_ff);
               f_iv = mk(xl_ff, smin(xu_ff, yu_ff));
            end
         end
         CondGe: begin
            if (xl_ff >= yu_ff) begin
               t_iv = '{lo: xl_ff, hi: xu_ff};
               f_iv = Empty;
            end else if (xu_ff < yl_ff) begin
               t_iv = Empty;
               f_iv = '{lo: xl_ff, hi: xu_ff};
            end else begin
               t_iv = mk(smax(xl_ff, yl_ff), xu_ff);
               f_iv = mk(xl_ff, smin(xu_ff, dec_sat(yu_ff)));
            end
         end
         default: begin
            t_iv = '{lo: xl_ff, hi: xu_ff};
            f_iv = '{lo: xl_ff, hi: xu_ff};
         end
      endcase
      case (s1_act_ff)
         ActAdd: begin
            s1_pl.rl = sat33(33'(xl_ff) + 33'(yl_ff));
            s1_pl.ru = sat33(33'(xu_ff) + 33'(yu_ff));
         end
         ActSub: begin
            s1_pl.rl = sat33(33'(xl_ff) - 33'(yu_ff));
            s1_pl.ru = sat33(33'(xu_ff) - 33'(yl_ff));
         end
         ActDiv: begin
            if (yl_ff <= 32'sd0 && yu_ff >= 32'sd0) begin
               s1_pl.rl = IntMin;
               s1_pl.ru = IntMax;
            end else begin
               s1_pl.is_div = 1'b1;
            end
         end
         ActRef: begin
            s1_pl.rl = t_iv.lo;
            s1_pl.ru = t_iv.hi;
            s1_pl.fl = f_iv.lo;
            s1_pl.fu = f_iv.hi;
         end
         default: begin
            s1_pl.rl = '0;
         end
      endcase
      s1_pl.neg = neg_in;
   end

   // corner lanes: xl/yl, xl/yu, xu/yl, xu/yu
   always_comb begin
      prod_in[0] = 64'(xl_ff) * 64'(yl_ff);
      prod_in[1] = 64'(xl_ff) * 64'(yu_ff);
      prod_in[2] = 64'(xu_ff) * 64'(yl_ff);
      prod_in[3] = 64'(xu_ff) * 64'(yu_ff);
      mag_n[0] = xl_ff[31] ? 32'(-xl_ff) : 32'(xl_ff);
      mag_n[1] = mag_n[0];
      mag_n[2] = xu_ff[31] ? 32'(-xu_ff) : 32'(xu_ff);
      mag_n[3] = mag_n[2];
      mag_d[0] = yl_ff[31] ? 32'(-yl_ff) : 32'(yl_ff);
      mag_d[1] = yu_ff[31] ? 32'(-yu_ff) : 32'(yu_ff);
      mag_d[2] = mag_d[0];
      mag_d[3] = mag_d[1];
      neg_in[0] = xl_ff[31] ^ yl_ff[31];
      neg_in[1] = xl_ff[31] ^ yu_ff[31];
      neg_in[2] = xu_ff[31] ^ yl_ff[31];
      neg_in[3] = xu_ff[31] ^ yu_ff[31];
   end

   // multiply span resolves alongside the first divider step
   always_comb begin
      pmin = prod_ff[0];
      pmax = prod_ff[0];
      for (int l = 1; l < 4; l++) begin
         if (prod_ff[l] < pmin) pmin = prod_ff[l];
         if (prod_ff[l] > pmax) pmax = prod_ff[l];
      end
   end

   // one restoring quotient bit per stage, four lanes each
   always_comb begin
      logic [32:0] t;
      logic        ge;
      for (int j = 0; j < Ds; j++) begin
         pl_in[j] = pl_ff[j];
         for (int l = 0; l < 4; l++) begin
            rem_in[j][l] = '0;
            quo_in[j][l] = '0;
         end
      end
      if (is_mul_ff) begin
         pl_in[0].rl = sat64(pmin);
         pl_in[0].ru = sat64(pmax);
      end
      for (int j = 0; j < Ds; j++) begin
         for (int l = 0; l < 4; l++) begin
            t  = {rem_ff[j][l], num_ff[j][l][31]};
            ge = (t >= {1'b0, den_ff[j][l]});
            rem_in[j][l] = ge ? 32'(t - {1'b0, den_ff[j][l]}) : t[31:0];
            quo_in[j][l] = {quo_ff[j][l][30:0], ge};
         end
      end
   end

   // stage 2: products and divider entry, then the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= s1_v_ff;
      end
      if (adv) begin
         pl_ff[0]  <= s1_pl;
         is_mul_ff <= (s1_act_ff == ActMul);
         for (int l = 0; l < 4; l++) begin
            prod_ff[l]   <= prod_in[l];
            num_ff[0][l] <= mag_n[l];
            den_ff[0][l] <= mag_d[l];
            rem_ff[0][l] <= '0;
            quo_ff[0][l] <= '0;
         end
      end
      for (int j = 0; j < Ds; j++) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            v_ff[j+1] <= v_ff[j];
         end
         if (adv) begin
            pl_ff[j+1] <= pl_in[j];
            for (int l = 0; l < 4; l++) begin
               rem_ff[j+1][l] <= rem_in[j][l];
               quo_ff[j+1][l] <= quo_in[j][l];
               num_ff[j+1][l] <= {num_ff[j][l][30:0], 1'b0};
               den_ff[j+1][l] <= den_ff[j][l];
            end
         end
      end
   end

   // signed quotients, span and saturation
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         q[l] = pl_ff[Ds].neg[l] ? -$signed({1'b0, quo_ff[Ds][l]})
                                 : $signed({1'b0, quo_ff[Ds][l]});
      end
      qmin = q[0];
      qmax = q[0];
      for (int l = 1; l < 4; l++) begin
         if (q[l] < qmin) qmin = q[l];
         if (q[l] > qmax) qmax = q[l];
      end
      fin_pl = pl_ff[Ds];
      if (pl_ff[Ds].is_div) begin
         fin_pl.rl = sat33(qmin);
         fin_pl.ru = sat33(qmax);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v_ff[Ds];
      end
      if (adv) begin
         out_pl_ff <= fin_pl;
      end
   end

   assign rsp_if.valid       = out_v_ff;
   assign rsp_if.res_lower   = out_pl_ff.rl;
   assign rsp_if.res_upper   = out_pl_ff.ru;
   assign rsp_if.false_lower = out_pl_ff.fl;
   assign rsp_if.false_upper = out_pl_ff.fu;

   `IARU_ASSERT_ALWAYS(a_reset_clears_out, $past(reset) |-> !out_v_ff, "response valid after reset")
   `IARU_ASSERT(a_stall_holds_pipe, !adv |=> $stable(v_ff[Ds]) && (!v_ff[Ds] || $stable(pl_ff[Ds])), "pipeline moved during stall")
   `IARU_ASSERT(a_false_zero, (out_v_ff && !out_pl_ff.is_ref) |-> (out_pl_ff.fl == 32'sd0 && out_pl_ff.fu == 32'sd0), "false branch set for arithmetic")

endmodule

// ===== test/iaru_scoreboard.sv =====
// checker of the interval arithmetic refine unit: watches both channels,
// predicts each response and compares it field by field
// depends on iaru_pkg, iaru_req_if and iaru_rsp_if
module iaru_scoreboard
   import iaru_pkg::*;
(
   input  logic clock,
   input  logic reset,
   iaru_req_if  req_mon,
   iaru_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic signed [31:0] rl;
      logic signed [31:0] ru;
      logic signed [31:0] fl;
      logic signed [31:0] fu;
   } answer_type;

   answer_type answer_q[$];

   function automatic longint clamp_bound(input longint v);
      if (v < longint'(IntMin)) return longint'(IntMin);
      if (v > longint'(IntMax)) return longint'(IntMax);
      return v;
   endfunction

   function automatic void pair_or_empty(input longint lo, input longint hi,
                                         output longint ol, output longint ou);
      if (lo <= hi) begin
         ol = lo;
         ou = hi;
      end else begin
         ol = 1;
         ou = -1;
      end
   endfunction

   function automatic longint lmin(input longint a, input longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint lmax(input longint a, input longint b);
      return (a > b) ? a : b;
   endfunction

   function automatic answer_type interval_answer(input logic [2:0] act,
                                                  input logic [2:0] cnd,
                                                  input longint xl, input longint xu,
                                                  input longint yl, input longint yu);
      longint rl, ru, fl, fu, lo, hi;
      longint c[4];
      answer_type r;
      rl = 0; ru = 0; fl = 0; fu = 0;
      case (act)
         ActAdd: begin
            rl = clamp_bound(xl + yl);
            ru = clamp_bound(xu + yu);
         end
         ActSub: begin
            rl = clamp_bound(xl - yu);
            ru = clamp_bound(xu - yl);
         end
         ActMul, ActDiv: begin
            if (act == ActDiv && yl <= 0 && yu >= 0) begin
               rl = longint'(IntMin);
               ru = longint'(IntMax);
            end else begin
               if (act == ActMul) begin
                  c[0] = xl * yl; c[1] = xl * yu; c[2] = xu * yl; c[3] = xu * yu;
               end else begin
                  c[0] = xl / yl; c[1] = xl / yu; c[2] = xu / yl; c[3] = xu / yu;
               end
               lo = c[0];
               hi = c[0];
               for (int i = 1; i < 4; i++) begin
                  lo = lmin(lo, c[i]);
                  hi = lmax(hi, c[i]);
               end
               rl = clamp_bound(lo);
               ru = clamp_bound(hi);
            end
         end
         ActRef: begin
            case (cnd)
               CondEq: begin
                  pair_or_empty(lmax(xl, yl), lmin(xu, yu), rl, ru);
                  fl = xl; fu = xu;
               end
               CondNe: begin
                  rl = xl; ru = xu;
                  pair_or_empty(lmax(xl, yl), lmin(xu, yu), fl, fu);
               end
               CondLt: begin
                  if (xu < yl) begin
                     rl = xl; ru = xu; fl = 1; fu = -1;
                  end else if (xl >= yu) begin
                     rl = 1; ru = -1; fl = xl; fu = xu;
                  end else begin
                     pair_or_empty(xl, lmin(xu, clamp_bound(yu - 1)), rl, ru);
                     pair_or_empty(lmax(xl, yl), xu, fl, fu);
                  end
               end
               CondLe: begin
                  if (xu <= yl) begin
                     rl = xl; ru = xu; fl = 1; fu = -1;
                  end else if (xl > yu) begin
                     rl = 1; ru = -1; fl = xl; fu = xu;
                  end else begin
                     pair_or_empty(xl, lmin(xu, yu), rl, ru);
                     pair_or_empty(lmax(xl, clamp_bound(yl + 1)), xu, fl, fu);
                  end
               end
               CondGt: begin
                  if (xl > yu) begin
                     rl = xl; ru = xu; fl = 1; fu = -1;
                  end else if (xu <= yl) begin
                     rl = 1; ru = -1; fl = xl; fu = xu;
                  end else begin
                     pair_or_empty(lmax(xl, clamp_bound(yl + 1)), xu, rl, ru);
                     pair_or_empty(xl, lmin(xu, yu), fl, fu);
                  end
               end
               CondGe: begin
                  if (xl >= yu) begin
                     rl = xl; ru = xu; fl = 1; fu = -1;
                  end else if (xu < yl) begin
                     rl = 1; ru = -1; fl = xl; fu = xu;
                  end else begin
                     pair_or_empty(lmax(xl, yl), xu, rl, ru);
                     pair_or_empty(xl, lmin(xu, clamp_bound(yu - 1)), fl, fu);
                  end
               end
               default: begin
                  rl = xl; ru = xu; fl = xl; fu = xu;
               end
            endcase
         end
         default: ;
      endcase
      r.rl = rl[31:0];
      r.ru = ru[31:0];
      r.fl = fl[31:0];
      r.fu = fu[31:0];
      return r;
   endfunction

   task automatic compare_field(input string name, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial fail_count = 0;
   initial pending = 0;

   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            answer_q.push_back(interval_answer(req_mon.action, req_mon.refine_cond,
                                               req_mon.a_lower, req_mon.a_upper,
                                               req_mon.b_lower, req_mon.b_upper));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answer_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               compare_field("res_lower", want.rl, rsp_mon.res_lower);
               compare_field("res_upper", want.ru, rsp_mon.res_upper);
               compare_field("false_lower", want.fl, rsp_mon.false_lower);
               compare_field("false_upper", want.fu, rsp_mon.false_upper);
            end
         end
      end
      pending = answer_q.size();
   end

endmodule

// ===== test/tb_top.sv =====
// testbench top of the interval arithmetic refine unit: clock, reset,
// directed and random request transactions, response stalls and the verdict
// depends on iaru_pkg, both channel interfaces, the rtl top and iaru_scoreboard
module tb_top;
   import iaru_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int RandomCount = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   int   fail_count;
   int   pending;
   int   cycles = 0;

   iaru_req_if req_if ();
   iaru_rsp_if rsp_if ();

   interval_arithmetic_refine_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   iaru_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // response stalls in random bursts
   initial begin
      rsp_if.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_if.ready = 1'b1;
         end
      end
   end

   function automatic logic signed [31:0] pick_bound();
      case ($urandom_range(0, 9))
         0: return IntMin;
         1: return IntMax;
         2: return 32'(int'($urandom_range(0, 6)) - 3);
         3: return IntMin + 32'($urandom_range(0, 3));
         4: return IntMax - 32'($urandom_range(0, 3));
         5, 6: return 32'(int'($urandom_range(0, 400)) - 200);
         7: return 32'(int'($urandom_range(0, 200000)) - 100000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_interval_op(input logic [2:0] act, input logic [2:0] cnd,
                                   input logic signed [31:0] al, input logic signed [31:0] au,
                                   input logic signed [31:0] bl, input logic signed [31:0] bu);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.action      = act;
      req_if.refine_cond = cnd;
      req_if.a_lower     = al;
      req_if.a_upper     = au;
      req_if.b_lower     = bl;
      req_if.b_upper     = bu;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic send_random_op();
      logic [2:0] act, cnd;
      logic signed [31:0] al, au, bl, bu, t;
      act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (act < 3'd5 && $urandom_range(0, 2) == 0) act = ActRef;
      cnd = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      al = pick_bound(); au = pick_bound(); bl = pick_bound(); bu = pick_bound();
      // mostly well-formed intervals, some crossed
      if ($urandom_range(0, 7) != 0 && al > au) begin
         t = al; al = au; au = t;
      end
      if ($urandom_range(0, 7) != 0 && bl > bu) begin
         t = bl; bl = bu; bu = t;
      end
      // a crossed divisor with a zero bound has no defined quotient
      if (act == ActDiv && bl > bu && (bl == 32'sd0 || bu == 32'sd0)) begin
         t = bl; bl = bu; bu = t;
      end
      send_interval_op(act, cnd, al, au, bl, bu);
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.action      = ActAdd;
      req_if.refine_cond = CondEq;
      req_if.a_lower     = '0;
      req_if.a_upper     = '0;
      req_if.b_lower     = '0;
      req_if.b_upper     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      send_interval_op(ActAdd, CondEq, IntMax, IntMax, 32'sd1, 32'sd5);
      send_interval_op(ActAdd, CondEq, IntMin, -32'sd1, IntMin, 32'sd0);
      send_interval_op(ActSub, CondEq, IntMin, IntMax, IntMin, IntMax);
      send_interval_op(ActMul, CondEq, IntMin, IntMax, IntMin, IntMax);
      send_interval_op(ActMul, CondEq, -32'sd3, 32'sd7, -32'sd2, 32'sd5);
      send_interval_op(ActDiv, CondEq, IntMin, IntMin, -32'sd1, -32'sd1);
      send_interval_op(ActDiv, CondEq, 32'sd10, 32'sd20, -32'sd5, 32'sd5);
      send_interval_op(ActDiv, CondEq, -32'sd7, 32'sd9, 32'sd2, 32'sd3);
      send_interval_op(ActDiv, CondEq, IntMax, IntMin, IntMin, -32'sd1);
      send_interval_op(ActRef, CondEq, 32'sd0, 32'sd10, 32'sd5, 32'sd20);
      send_interval_op(ActRef, CondEq, 32'sd0, 32'sd3, 32'sd5, 32'sd20);
      send_interval_op(ActRef, CondNe, 32'sd0, 32'sd10, 32'sd5, 32'sd20);
      send_interval_op(ActRef, CondNe, 32'sd0, 32'sd3, 32'sd5, 32'sd20);
      send_interval_op(ActRef, CondLt, 32'sd0, 32'sd3, 32'sd5, 32'sd20);
      send_interval_op(ActRef, CondLt, 32'sd0, 32'sd10, IntMin, IntMin);
      send_interval_op(ActRef, CondLe, 32'sd0, 32'sd10, 32'sd5, 32'sd8);
      send_interval_op(ActRef, CondLe, IntMin, IntMax, IntMax, IntMax);
      send_interval_op(ActRef, CondGt, 32'sd0, 32'sd10, IntMax, IntMax);
      send_interval_op(ActRef, CondGt, 32'sd20, 32'sd30, 32'sd5, 32'sd8);
      send_interval_op(ActRef, CondGe, IntMin, IntMax, IntMin, IntMin);
      send_interval_op(ActRef, CondGe, 32'sd0, 32'sd10, 32'sd5, 32'sd8);
      send_interval_op(ActRef, CondLt, 32'sd10, 32'sd0, 32'sd3, 32'sd4);
      send_interval_op(ActRef, 3'd6, -32'sd1, 32'sd1, 32'sd0, 32'sd0);
      send_interval_op(ActRef, 3'd7, 32'sd4, 32'sd2, 32'sd0, 32'sd0);
      send_interval_op(3'd5, CondEq, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
      send_interval_op(3'd7, 3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

      for (int n = 0; n < RandomCount; n++) begin
         if (n == RandomCount / 2) begin
            req_if.valid = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         if (n == RandomCount - 100) quiet = 1'b1;
         send_random_op();
      end
      req_if.valid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/iaru_pkg.sv
rtl/iaru_req_if.sv
rtl/iaru_rsp_if.sv
rtl/interval_arithmetic_refine_unit.sv
test/iaru_scoreboard.sv
test/tb_top.sv
